FILE: rtl/md4_pkg.sv
`default_nettype none
package md4_pkg;

  // MD4 initial chaining words.
  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hefcdab89;
  localparam logic [31:0] H2_INIT = 32'h98badcfe;
  localparam logic [31:0] H3_INIT = 32'h10325476;

  // Additive constants of the second and third round groups.
  localparam logic [31:0] K_GRP1 = 32'h5a827999;
  localparam logic [31:0] K_GRP2 = 32'h6ed9eba1;

  // Round groups of sixteen steps each.
  localparam logic [1:0] GRP_F = 2'd0;
  localparam logic [1:0] GRP_G = 2'd1;
  localparam logic [1:0] GRP_H = 2'd2;

  // Byte positions inside a block that steer padding.
  localparam logic [5:0] POS_LAST    = 6'd63;
  localparam logic [5:0] POS_PAD_END = 6'd55;

  localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
  localparam int unsigned STEP_LAST = 47;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD_MARK,
    S_PAD_ZERO,
    S_PAD_LEN,
    S_ROUND,
    S_ADD,
    S_LOAD
  } md4_state_t;

  typedef enum logic [1:0] {
    BYTE_DATA,
    BYTE_MARK,
    BYTE_ZERO,
    BYTE_LEN
  } md4_byte_src_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic          cnt_inc;
    logic          wr_en;
    md4_byte_src_t wr_src;
    logic          wr_at_pad;
    logic          pad_load;
    logic          pad_inc;
    logic          cmp_start;
    logic          round_en;
    logic          chain_add;
    logic          out_load;
  } md4_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [5:0] cnt_pos;
    logic [5:0] pad_pos;
    logic       round_last;
    logic       out_busy;
  } md4_status_t;

  // Message word used by step j of a round group.
  function automatic logic [3:0] word_sel(input logic [1:0] grp, input logic [3:0] j);
    logic [3:0] w;
    begin
      unique case (grp)
        GRP_F:   w = j;
        GRP_G:   w = {j[1:0], j[3:2]};
        GRP_H:   w = {j[0], j[1], j[2], j[3]};
        default: w = j;
      endcase
      return w;
    end
  endfunction

  // Right rotation amount of a step.
  function automatic logic [4:0] rot_amt(input logic [1:0] grp, input logic [1:0] j);
    logic [4:0] s;
    begin
      unique case ({grp, j})
        {GRP_F, 2'd0}, {GRP_G, 2'd0}, {GRP_H, 2'd0}: s = 5'd29;
        {GRP_F, 2'd1}: s = 5'd25;
        {GRP_F, 2'd2}: s = 5'd21;
        {GRP_F, 2'd3}: s = 5'd13;
        {GRP_G, 2'd1}: s = 5'd27;
        {GRP_G, 2'd2}: s = 5'd23;
        {GRP_G, 2'd3}: s = 5'd19;
        {GRP_H, 2'd1}: s = 5'd23;
        {GRP_H, 2'd2}: s = 5'd21;
        {GRP_H, 2'd3}: s = 5'd17;
        default:       s = 5'd29;
      endcase
      return s;
    end
  endfunction

  // Additive constant of a round group.
  function automatic logic [31:0] step_add(input logic [1:0] grp);
    logic [31:0] k;
    begin
      unique case (grp)
        GRP_G:   k = K_GRP1;
        GRP_H:   k = K_GRP2;
        default: k = 32'd0;
      endcase
      return k;
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/md4_ctrl.sv
`default_nettype none
module md4_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_fire,
  input  wire logic               has_byte,
  input  wire logic               is_last,
  input  wire md4_pkg::md4_status_t sts,
  output logic                    in_ready,
  output md4_pkg::md4_cmd_t       cmd
);

  md4_pkg::md4_state_t state_r, state_nxt;
  md4_pkg::md4_state_t ret_r, ret_nxt;

  // State and return-target registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= md4_pkg::S_IDLE;
      ret_r   <= md4_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  // Next state. A compression returns to the state held in ret_r.
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    unique case (state_r)
      md4_pkg::S_IDLE: begin
        if (in_fire) begin
          if (has_byte && sts.cnt_pos == md4_pkg::POS_LAST) begin
            state_nxt = md4_pkg::S_ROUND;
            ret_nxt   = is_last ? md4_pkg::S_PAD_MARK : md4_pkg::S_IDLE;
          end else if (is_last) begin
            state_nxt = md4_pkg::S_PAD_MARK;
          end
        end
      end
      md4_pkg::S_PAD_MARK: begin
        if (sts.cnt_pos == md4_pkg::POS_LAST) begin
          state_nxt = md4_pkg::S_ROUND;
          ret_nxt   = md4_pkg::S_PAD_ZERO;
        end else if (sts.cnt_pos == md4_pkg::POS_PAD_END) begin
          state_nxt = md4_pkg::S_PAD_LEN;
        end else begin
          state_nxt = md4_pkg::S_PAD_ZERO;
        end
      end
      md4_pkg::S_PAD_ZERO: begin
        if (sts.pad_pos == md4_pkg::POS_LAST) begin
          state_nxt = md4_pkg::S_ROUND;
          ret_nxt   = md4_pkg::S_PAD_ZERO;
        end else if (sts.pad_pos == md4_pkg::POS_PAD_END) begin
          state_nxt = md4_pkg::S_PAD_LEN;
        end
      end
      md4_pkg::S_PAD_LEN: begin
        if (sts.pad_pos == md4_pkg::POS_LAST) begin
          state_nxt = md4_pkg::S_ROUND;
          ret_nxt   = md4_pkg::S_LOAD;
        end
      end
      md4_pkg::S_ROUND: begin
        if (sts.round_last) begin
          state_nxt = md4_pkg::S_ADD;
        end
      end
      md4_pkg::S_ADD: begin
        state_nxt = ret_r;
      end
      md4_pkg::S_LOAD: begin
        if (!sts.out_busy) begin
          state_nxt = md4_pkg::S_IDLE;
        end
      end
      default: state_nxt = md4_pkg::S_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.wr_src    = md4_pkg::BYTE_DATA;
    cmd.cmp_start = (state_nxt == md4_pkg::S_ROUND) && (state_r != md4_pkg::S_ROUND);
    unique case (state_r)
      md4_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.cnt_inc = in_fire && has_byte;
        cmd.wr_en   = in_fire && has_byte;
      end
      md4_pkg::S_PAD_MARK: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_src   = md4_pkg::BYTE_MARK;
        cmd.pad_load = 1'b1;
      end
      md4_pkg::S_PAD_ZERO: begin
        cmd.wr_en     = 1'b1;
        cmd.wr_src    = md4_pkg::BYTE_ZERO;
        cmd.wr_at_pad = 1'b1;
        cmd.pad_inc   = 1'b1;
      end
      md4_pkg::S_PAD_LEN: begin
        cmd.wr_en     = 1'b1;
        cmd.wr_src    = md4_pkg::BYTE_LEN;
        cmd.wr_at_pad = 1'b1;
        cmd.pad_inc   = 1'b1;
      end
      md4_pkg::S_ROUND: cmd.round_en  = 1'b1;
      md4_pkg::S_ADD:   cmd.chain_add = 1'b1;
      md4_pkg::S_LOAD:  cmd.out_load  = !sts.out_busy;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/md4_datapath.sv
`default_nettype none
module md4_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire md4_pkg::md4_cmd_t cmd,
  input  wire logic [7:0]        data_byte,
  output md4_pkg::md4_status_t   sts,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [31:0]            out_word,
  output logic [1:0]             out_index,
  output logic                   out_last
);

  logic [31:0] blk_r [16];
  logic [31:0] chain_r [4];
  logic [31:0] obuf_r [4];
  logic [60:0] cnt_r, cnt_nxt;
  logic [5:0]  pad_r, pad_nxt;
  logic [5:0]  round_r, round_nxt;
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [1:0]  oidx_r, oidx_nxt;
  logic        ovalid_r, ovalid_nxt;

  logic [5:0]  wr_pos;
  logic [7:0]  wr_val;
  logic [63:0] len_bits;
  logic [1:0]  grp;
  logic [31:0] f_val;
  logic [31:0] t_sum;
  logic [63:0] t_dbl;
  logic [31:0] b_new;
  logic        out_fire;

  // Byte to be written into the block buffer.
  assign len_bits = {cnt_r, 3'b000};
  assign wr_pos   = cmd.wr_at_pad ? pad_r : cnt_r[5:0];
  always_comb begin
    case (cmd.wr_src)
      md4_pkg::BYTE_DATA: wr_val = data_byte;
      md4_pkg::BYTE_MARK: wr_val = md4_pkg::PAD_MARK_BYTE;
      md4_pkg::BYTE_LEN:  wr_val = len_bits[{pad_r[2:0], 3'b000} +: 8];
      default:            wr_val = 8'd0;
    endcase
  end

  // Block buffer, little-endian bytes within each word.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      blk_r[wr_pos[5:2]][{wr_pos[1:0], 3'b000} +: 8] <= wr_val;
    end
  end

  // One MD4 step per cycle.
  assign grp = round_r[5:4];
  always_comb begin
    case (grp)
      md4_pkg::GRP_F: f_val = ((c_r ^ d_r) & b_r) ^ d_r;
      md4_pkg::GRP_G: f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      default:        f_val = b_r ^ c_r ^ d_r;
    endcase
  end
  assign t_sum = a_r + blk_r[md4_pkg::word_sel(grp, round_r[3:0])]
               + md4_pkg::step_add(grp) + f_val;
  assign t_dbl = {t_sum, t_sum} >> md4_pkg::rot_amt(grp, round_r[1:0]);
  assign b_new = t_dbl[31:0];

  // Working variables.
  always_ff @(posedge clk) begin
    if (cmd.cmp_start) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
    end else if (cmd.round_en) begin
      a_r <= d_r;
      b_r <= b_new;
      c_r <= b_r;
      d_r <= c_r;
    end
  end

  // Counters for bytes, padding position and steps.
  always_comb begin
    cnt_nxt   = cnt_r;
    pad_nxt   = pad_r;
    round_nxt = round_r;
    if (cmd.out_load) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + 61'd1;
    end
    if (cmd.pad_load) begin
      pad_nxt = cnt_r[5:0] + 6'd1;
    end else if (cmd.pad_inc) begin
      pad_nxt = pad_r + 6'd1;
    end
    if (cmd.cmp_start) begin
      round_nxt = '0;
    end else if (cmd.round_en) begin
      round_nxt = round_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      pad_r   <= '0;
      round_r <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      pad_r   <= pad_nxt;
      round_r <= round_nxt;
    end
  end

  // Chaining words: feed-forward after a block, reinit after the digest.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.out_load) begin
      chain_r[0] <= md4_pkg::H0_INIT;
      chain_r[1] <= md4_pkg::H1_INIT;
      chain_r[2] <= md4_pkg::H2_INIT;
      chain_r[3] <= md4_pkg::H3_INIT;
    end else if (cmd.chain_add) begin
      chain_r[0] <= chain_r[0] + a_r;
      chain_r[1] <= chain_r[1] + b_r;
      chain_r[2] <= chain_r[2] + c_r;
      chain_r[3] <= chain_r[3] + d_r;
    end
  end

  // Digest buffer drains while the next message is taken.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      obuf_r[0] <= chain_r[0];
      obuf_r[1] <= chain_r[1];
      obuf_r[2] <= chain_r[2];
      obuf_r[3] <= chain_r[3];
    end
  end

  assign out_fire = ovalid_r && out_ready;
  always_comb begin
    ovalid_nxt = ovalid_r;
    oidx_nxt   = oidx_r;
    if (cmd.out_load) begin
      ovalid_nxt = 1'b1;
      oidx_nxt   = '0;
    end else if (out_fire) begin
      oidx_nxt = oidx_r + 2'd1;
      if (oidx_r == 2'd3) begin
        ovalid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
      oidx_r   <= '0;
    end else begin
      ovalid_r <= ovalid_nxt;
      oidx_r   <= oidx_nxt;
    end
  end

  assign out_valid = ovalid_r;
  assign out_word  = obuf_r[oidx_r];
  assign out_index = oidx_r;
  assign out_last  = (oidx_r == 2'd3);

  // Status to the controller.
  assign sts.cnt_pos    = cnt_r[5:0];
  assign sts.pad_pos    = pad_r;
  assign sts.round_last = (round_r == 6'(md4_pkg::STEP_LAST));
  assign sts.out_busy   = ovalid_r;

endmodule
`default_nettype wire

FILE: rtl/md4_digest_core.sv
`default_nettype none
// MD4 digest engine, one message byte per input item.
// Input channel: in_tdata carries the message byte, in_tuser[0] says whether
// the byte is valid (0 marks a bare end of message), in_tlast ends the message.
// Output channel: four items per message, h0 to h3 of the digest, each a
// little-endian 32-bit word, with out_tuser the word index and out_tlast on h3.
// Message bytes are taken one per cycle until a 64-byte block is full; that
// block then holds in_tready low while the single shared step unit runs its
// 48 steps and the feed-forward add follows.
// On the last item the padding is written one byte per cycle (0x80, zero fill,
// eight length bytes), paused for a block compression wherever a block fills;
// one or two compressions run in all, and the digest buffer is then loaded.
// The digest sits in its own buffer, so a stalled receiver does not stop the
// next message; only the next digest load waits until the buffer has drained.
// Synchronous reset restores the MD4 initial chaining words, clears the byte
// count and drops the output valid.
module md4_digest_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic [0:0]  in_tuser,   // [0] has_byte
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] digest_word
  output logic [1:0]       out_tuser,  // [1:0] word_index
  output logic             out_tlast
);

  md4_pkg::md4_cmd_t    cmd;
  md4_pkg::md4_status_t sts;
  logic                 in_fire;

  assign in_fire = in_tvalid && in_tready;

  md4_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .has_byte (in_tuser[0]),
    .is_last  (in_tlast),
    .sts      (sts),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  md4_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .data_byte (in_tdata),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (out_tdata),
    .out_index (out_tuser),
    .out_last  (out_tlast)
  );

endmodule
`default_nettype wire

FILE: tb/tb_md4_digest_core.sv
`timescale 1ns / 1ps

module tb_md4_digest_core;

  // MD4 initial chaining words and round constants.
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [31:0] K_ROUND2 = 32'h5a827999;
  localparam logic [31:0] K_ROUND3 = 32'h6ed9eba1;
  localparam logic [7:0]  PAD_MARK = 8'h80;
  localparam int          LEN_OFFSET = 56;
  localparam int          BLOCK_BYTES = 64;
  localparam int          HOLD_CYCLES = 600;
  localparam int          DRAIN_CYCLES = 250;

  typedef struct packed {
    logic [31:0] digest;
    logic [1:0]  widx;
    logic        is_final;
  } digest_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;  // [7:0] data_byte
  logic [0:0]  in_tuser = 1'b0;   // [0] has_byte
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [31:0] digest_word
  logic [1:0]  out_tuser;         // [1:0] word_index
  logic        out_tlast;

  // Model state of the digest engine.
  logic [31:0] chain_h [4];
  logic [31:0] msg_words [16];
  logic [60:0] msg_bytes;

  digest_word_t digest_q [$];
  int err_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;

  md4_digest_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  // Right rotation amount for step k of round r.
  function automatic int rot_amount(input int r, input int k);
    int s;
    case (r * 4 + k)
      0, 4, 8: s = 29;
      1:       s = 25;
      2, 10:   s = 21;
      3:       s = 13;
      5:       s = 27;
      6, 9:    s = 23;
      7:       s = 19;
      default: s = 17;
    endcase
    return s;
  endfunction

  task automatic start_message();
    chain_h[0] = IV_A;
    chain_h[1] = IV_B;
    chain_h[2] = IV_C;
    chain_h[3] = IV_D;
    msg_bytes = '0;
  endtask

  task automatic put_msg_byte(input logic [5:0] pos, input logic [7:0] b);
    msg_words[pos[5:2]][{pos[1:0], 3'b000} +: 8] = b;
  endtask

  // Runs the 48 steps over the current block and adds into the chain.
  task automatic md4_compress();
    logic [31:0] a, b, c, d, f, k, t;
    logic [3:0]  j;
    logic [3:0]  w;
    int          r, s;
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    for (int i = 0; i < 48; i++) begin
      r = i / 16;
      j = i[3:0];
      case (r)
        0: begin
          f = ((c ^ d) & b) ^ d;
          k = '0;
          w = j;
        end
        1: begin
          f = (b & c) | (b & d) | (c & d);
          k = K_ROUND2;
          w = 4'((j % 4) * 4 + j / 4);
        end
        default: begin
          f = b ^ c ^ d;
          k = K_ROUND3;
          w = 4'(j[0] * 8 + j[1] * 4 + j[2] * 2 + j[3]);
        end
      endcase
      t = a + msg_words[w] + k + f;
      s = rot_amount(r, i % 4);
      t = (t >> s) | (t << (32 - s));
      a = d;
      d = c;
      c = b;
      b = t;
    end
    chain_h[0] = chain_h[0] + a;
    chain_h[1] = chain_h[1] + b;
    chain_h[2] = chain_h[2] + c;
    chain_h[3] = chain_h[3] + d;
  endtask

  // Absorbs one accepted item; on the end of a message it pads, finishes
  // and queues the four digest words.
  task automatic md4_absorb(input logic [7:0] data, input bit has, input bit last);
    logic [6:0]   p;
    logic [63:0]  bitlen;
    digest_word_t dw;
    if (has) begin
      p = {1'b0, msg_bytes[5:0]};
      put_msg_byte(p[5:0], data);
      msg_bytes = msg_bytes + 61'd1;
      if (p == 7'(BLOCK_BYTES - 1))
        md4_compress();
    end
    if (last) begin
      p = {1'b0, msg_bytes[5:0]};
      put_msg_byte(p[5:0], PAD_MARK);
      p++;
      // No room for the length: close this block and pad a second one.
      if (p > 7'(LEN_OFFSET)) begin
        while (p < 7'(BLOCK_BYTES)) begin
          put_msg_byte(p[5:0], 8'h00);
          p++;
        end
        md4_compress();
        p = '0;
      end
      while (p < 7'(LEN_OFFSET)) begin
        put_msg_byte(p[5:0], 8'h00);
        p++;
      end
      bitlen = {msg_bytes, 3'b000};
      for (int i = 0; i < 8; i++)
        put_msg_byte(6'(LEN_OFFSET + i), bitlen[8 * i +: 8]);
      md4_compress();
      for (int i = 0; i < 4; i++) begin
        dw.digest = chain_h[i];
        dw.widx = i[1:0];
        dw.is_final = (i == 3);
        digest_q = {digest_q, dw};
      end
      start_message();
    end
  endtask

  // Offers one item, with random idle cycles first, and waits for acceptance.
  task automatic send_item(input logic [7:0] data, input bit has, input bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= data;
    in_tuser <= has;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    md4_absorb(data, has, last);
  endtask

  // Sends a message of random bytes, ended either on its last byte or by a
  // bare end marker, with ignored items mixed in.
  task automatic send_message(input int nbytes, input bit bare_end, input int noise_pct);
    for (int i = 0; i < nbytes; i++) begin
      if ($urandom_range(99) < noise_pct)
        send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(255)), 1'b1, (i == nbytes - 1) && !bare_end);
    end
    if (bare_end || nbytes == 0)
      send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // Short messages, the empty message, ignored items and extreme byte values.
  task automatic test_directed();
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'ha5, 1'b0, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h7f, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);
  endtask

  // One message that fills a whole block mid-message and then ends where
  // the padding needs a second block.
  task automatic test_block_edges();
    send_message(121, 1'b0, 0);
  endtask

  // The receiver holds off while several short messages go in, so the
  // digest buffer fills and the input stalls.
  task automatic test_output_holdoff();
    hold_seq++;
    for (int i = 0; i < 3; i++)
      send_message(1, i[0], 0);
  endtask

  // Random short messages under each idling phase.
  task automatic test_random();
    int len;
    for (int m = 0; m < 8; m++) begin
      case (m / 2)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      len = $urandom_range(3);
      send_message(len, ($urandom_range(3) == 0), 10);
    end
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compares each accepted digest word with the oldest expected one.
  always @(posedge clk) begin
    digest_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest word, actual %h idx %0d last %b",
                 $time, out_tdata, out_tuser, out_tlast);
        err_count++;
      end else begin
        want = digest_q.pop_front();
        if (out_tdata !== want.digest) begin
          $display("%0t: digest word mismatch, expected %h actual %h",
                   $time, want.digest, out_tdata);
          err_count++;
        end
        if (out_tuser !== want.widx) begin
          $display("%0t: word index mismatch, expected %0d actual %0d",
                   $time, want.widx, out_tuser);
          err_count++;
        end
        if (out_tlast !== want.is_final) begin
          $display("%0t: last word flag mismatch, expected %b actual %b",
                   $time, want.is_final, out_tlast);
          err_count++;
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    for (int i = 0; i < 16; i++)
      msg_words[i] = '0;
    start_message();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    send_idle_pct = 73;
    test_block_edges();
    send_idle_pct = 0;
    test_output_holdoff();
    test_random();

    in_tvalid <= 1'b0;
    while (digest_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && digest_q.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

FILE: sim.f
rtl/md4_pkg.sv
rtl/md4_ctrl.sv
rtl/md4_datapath.sv
rtl/md4_digest_core.sv
tb/tb_md4_digest_core.sv
